// File: rtl/tlc_pkg.sv
`default_nettype none
package tlc_pkg;

  localparam int ADDR_W     = 32;
  localparam int LINE_BYTES = 64;
  localparam int L1_LINES   = 512;
  localparam int L2_SETS    = 1024;
  localparam int L2_WAYS    = 4;

  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int L1_IDX_W   = $clog2(L1_LINES);
  localparam int L1_TAG_W   = ADDR_W - OFF_W - L1_IDX_W;
  localparam int L1_DEPTH   = 2 * L1_LINES;
  localparam int L1_ADDR_W  = $clog2(L1_DEPTH);
  localparam int L2_SET_W   = $clog2(L2_SETS);
  localparam int L2_TAG_W   = ADDR_W - OFF_W - L2_SET_W;
  localparam int WAY_W      = $clog2(L2_WAYS);

  localparam int CLR_DEPTH  = (L1_DEPTH > L2_SETS) ? L1_DEPTH : L2_SETS;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  localparam int LFSR_W     = 16;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;

  // Access kinds carried on the input tuser.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [L1_TAG_W-1:0] tag;
  } l1_row_t;

  typedef struct packed {
    logic [L2_WAYS-1:0]               valid;
    logic [L2_WAYS-1:0][L2_TAG_W-1:0] tag;
  } l2_row_t;

  typedef struct packed {
    logic hit;
    logic dram_read;
    logic evict;
  } l2_flags_t;

endpackage
`default_nettype wire

// File: rtl/tlc_l2_set_update.sv
`default_nettype none
module tlc_l2_set_update import tlc_pkg::*; (
  input  wire l2_row_t             row,
  input  wire logic [L2_TAG_W-1:0] tag,
  input  wire logic                is_read,
  input  wire logic [LFSR_W-1:0]   lfsr,
  output l2_row_t                  row_next,
  output l2_flags_t                flags,
  output logic [LFSR_W-1:0]        lfsr_next
);

  logic             hit;
  logic             found_empty;
  logic [WAY_W-1:0] empty_way;
  logic [WAY_W-1:0] fill_way;

  // Tag compare across the set, then the lowest empty way or the LFSR victim.
  always_comb begin
    hit         = 1'b0;
    found_empty = 1'b0;
    empty_way   = '0;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (row.valid[w] && row.tag[w] == tag) begin
        hit = 1'b1;
      end
    end
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (!row.valid[w]) begin
        found_empty = 1'b1;
        empty_way   = WAY_W'(w);
      end
    end
    fill_way = found_empty ? empty_way : lfsr[WAY_W-1:0];
    row_next = row;
    row_next.valid[fill_way] = 1'b1;
    row_next.tag[fill_way]   = tag;
  end

  assign flags.hit       = hit;
  assign flags.dram_read = !hit && is_read;
  assign flags.evict     = !hit && !found_empty;

  // Fibonacci LFSR, taps 16,14,13,11.
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};

endmodule
`default_nettype wire

// File: rtl/two_level_cache_tag_hierarchy_top.sv
// Tag model of a two-level cache: split direct-mapped L1 (data and
// instruction halves) in front of a shared 4-way set-associative L2.
//
// Input channel s_*: one item is one access. tuser carries the access kind
// (read, write, fetch, or the unused code that touches nothing) and tdata
// the 32-bit byte address. Output channel m_*: one item per access with the
// hit and DRAM traffic flags.
//
// At the accepting edge of an access the L1 row and the L2 set are read
// from their memories; in the resolve state the tags are compared, and
// once the output register is free the rows are written back and the
// result is registered, so the result shows on m_tvalid after the resolve
// step. The block takes no new item until the last one has been resolved.
// The cost is the registered memory read followed by the dependent write back.
//
// After reset a clearing pass sweeps both memories, one row per cycle, and
// s_tready stays low until every row is cleared. The LFSR restarts from its
// seed. If the receiver stalls, the block still accepts one more item and
// parks it, memories untouched, until the output register frees up.
// cfg_we loads the replacement seed (zero is replaced by the reset seed).
`default_nettype none
module two_level_cache_tag_hierarchy_top import tlc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [ADDR_W-1:0]   s_tdata,   // [31:0] address
  input  wire logic [1:0]          s_tuser,   // [1:0] mode
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [7:0]               m_tdata,   // [0] l1_hit, [1] l2_accessed,
                                              // [2] l2_hit, [3] dram_read,
                                              // [4] dram_write, [7:5] zero
  input  wire logic                cfg_we,
  input  wire logic [LFSR_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    ST_CLEAR   = 3'b001,
    ST_IDLE    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  typedef struct packed {
    logic dram_write;
    logic dram_read;
    logic l2_hit;
    logic l2_accessed;
    logic l1_hit;
  } result_t;

  state_t              state;
  state_t              state_next;
  logic [CLR_W-1:0]    clr_cnt;
  logic [LFSR_W-1:0]   lfsr;

  // The access being resolved.
  logic [1:0]          mode;
  logic [L1_ADDR_W-1:0] l1_idx;
  logic [L1_TAG_W-1:0] l1_tag;
  logic [L2_SET_W-1:0] l2_set;
  logic [L2_TAG_W-1:0] l2_tag;

  // Tag memories with registered read data.
  l1_row_t             l1_mem [L1_DEPTH];
  l2_row_t             l2_mem [L2_SETS];
  l1_row_t             l1_rd;
  l2_row_t             l2_rd;

  result_t             res;
  result_t             res_next;

  logic                accept;
  logic                advance;
  logic                l1_hit;
  logic                l1_we;
  logic                l2_we;
  logic                l2_used;
  l2_row_t             l2_row_next;
  l2_flags_t           l2_flags;
  logic [LFSR_W-1:0]   lfsr_step;
  logic [L1_ADDR_W-1:0] in_l1_idx;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign advance  = (state == ST_RESOLVE) && (!m_tvalid || m_tready);

  // The instruction half sits above the data half in the L1 store.
  assign in_l1_idx = {s_tuser == MODE_FETCH, s_tdata[OFF_W +: L1_IDX_W]};

  always_ff @(posedge clk) begin
    if (accept) begin
      mode   <= s_tuser;
      l1_idx <= in_l1_idx;
      l1_tag <= s_tdata[ADDR_W-1 -: L1_TAG_W];
      l2_set <= s_tdata[OFF_W +: L2_SET_W];
      l2_tag <= s_tdata[ADDR_W-1 -: L2_TAG_W];
      l1_rd  <= l1_mem[in_l1_idx];
      l2_rd  <= l2_mem[s_tdata[OFF_W +: L2_SET_W]];
    end
  end

  tlc_l2_set_update u_l2_set (
    .row       (l2_rd),
    .tag       (l2_tag),
    .is_read   (mode != MODE_WRITE),
    .lfsr      (lfsr),
    .row_next  (l2_row_next),
    .flags     (l2_flags),
    .lfsr_next (lfsr_step)
  );

  // A read or fetch goes to L2 only on an L1 miss; a write always does.
  always_comb begin
    l1_hit  = l1_rd.valid && (l1_rd.tag == l1_tag);
    l2_used = 1'b0;
    l1_we   = 1'b0;
    unique case (mode)
      MODE_READ, MODE_FETCH: begin
        l2_used = !l1_hit;
        l1_we   = !l1_hit;
      end
      MODE_WRITE: begin
        l2_used = 1'b1;
        l1_we   = !l1_hit;
      end
      default: begin
        l2_used = 1'b0;
        l1_we   = 1'b0;
      end
    endcase
    l2_we = l2_used && !l2_flags.hit;

    res_next.l1_hit      = (mode != MODE_NONE) && l1_hit;
    res_next.l2_accessed = l2_used;
    res_next.l2_hit      = l2_used && l2_flags.hit;
    res_next.dram_read   = l2_used && l2_flags.dram_read;
    res_next.dram_write  = l2_used && l2_flags.evict;
  end

  // Write port: clearing sweep after reset, write back otherwise.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      if (32'(clr_cnt) < L1_DEPTH) begin
        l1_mem[clr_cnt[L1_ADDR_W-1:0]] <= '0;
      end
      if (32'(clr_cnt) < L2_SETS) begin
        l2_mem[clr_cnt[L2_SET_W-1:0]] <= '0;
      end
    end else if (advance) begin
      if (l1_we) begin
        l1_mem[l1_idx] <= '{valid: 1'b1, tag: l1_tag};
      end
      if (l2_we) begin
        l2_mem[l2_set] <= l2_row_next;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (32'(clr_cnt) == CLR_DEPTH - 1) state_next = ST_IDLE;
      ST_IDLE:    if (accept) state_next = ST_RESOLVE;
      ST_RESOLVE: if (advance) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      lfsr     <= SEED_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      priority if (cfg_we) begin
        lfsr <= (cfg_wdata == '0) ? SEED_RESET : cfg_wdata;
      end else if (advance && l2_used && l2_flags.evict) begin
        lfsr <= lfsr_step;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {3'b000, res};

  // Every accepted access moves to the resolve state in the following cycle.
  a_accept_resolves: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_RESOLVE)
    else $error("accepted access did not move to resolve");

  // A new result appears only out of a resolve step.
  a_result_from_resolve: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RESOLVE))
    else $error("result appeared without a resolve step");

  // DRAM traffic only comes from an L2 miss.
  a_dram_needs_l2_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.dram_read || res.dram_write) |-> res.l2_accessed && !res.l2_hit)
    else $error("DRAM flag without an L2 miss");

  // A read or fetch that hits L1 never reaches L2.
  a_l1_hit_filters: assert property (@(posedge clk) disable iff (rst)
    advance && mode != MODE_WRITE && res_next.l1_hit |-> !l2_we && !l1_we)
    else $error("L1 read hit still updated the tag stores");

endmodule
`default_nettype wire

// File: bench/cache_tag_checker.sv
`default_nettype none
// Watches both streams and the seed port, keeps a shadow copy of the L1 and
// L2 tag stores, and checks every result item against the oldest prediction.
module cache_tag_checker import tlc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [ADDR_W-1:0] s_tdata,
  input  wire logic [1:0]        s_tuser,
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [7:0]        m_tdata,
  input  wire logic              cfg_we,
  input  wire logic [LFSR_W-1:0] cfg_wdata,
  output int                     error_count,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic l1_hit;
    logic l2_accessed;
    logic l2_hit;
    logic dram_read;
    logic dram_write;
  } access_flags_t;

  logic                l1_valid [L1_DEPTH];
  logic [L1_TAG_W-1:0] l1_tag   [L1_DEPTH];
  logic                l2_valid [L2_SETS*L2_WAYS];
  logic [L2_TAG_W-1:0] l2_tag   [L2_SETS*L2_WAYS];
  logic [LFSR_W-1:0]   victim_lfsr;

  access_flags_t pending_flags_q[$];

  // Looks up the shared L2 and fills it on a miss; an eviction advances the LFSR.
  function automatic void l2_lookup(input logic [ADDR_W-1:0] addr, input logic is_read,
                                    inout access_flags_t flags);
    int                  base;
    int                  victim;
    logic [L2_TAG_W-1:0] tag;
    base = int'(addr[OFF_W +: L2_SET_W]) * L2_WAYS;
    tag  = addr[ADDR_W-1 -: L2_TAG_W];
    flags.l2_accessed = 1'b1;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (l2_valid[base+w] && (l2_tag[base+w] == tag)) begin
        flags.l2_hit = 1'b1;
        return;
      end
    end
    flags.dram_read = is_read;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (!l2_valid[base+w]) begin
        l2_valid[base+w] = 1'b1;
        l2_tag[base+w]   = tag;
        return;
      end
    end
    victim = int'(victim_lfsr[WAY_W-1:0]);
    victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                   victim_lfsr[LFSR_W-1:1]};
    l2_valid[base+victim] = 1'b1;
    l2_tag[base+victim]   = tag;
    flags.dram_write = 1'b1;
  endfunction

  function automatic access_flags_t predict_access(input logic [1:0] kind,
                                                   input logic [ADDR_W-1:0] addr);
    access_flags_t       flags;
    int                  slot;
    logic [L1_TAG_W-1:0] tag;
    logic                hit;
    flags = '0;
    if (kind == MODE_NONE) return flags;
    slot = ((kind == MODE_FETCH) ? L1_LINES : 0) + int'(addr[OFF_W +: L1_IDX_W]);
    tag  = addr[ADDR_W-1 -: L1_TAG_W];
    hit  = l1_valid[slot] && (l1_tag[slot] == tag);
    flags.l1_hit = hit;
    if (kind == MODE_WRITE) begin
      if (!hit) begin
        l1_valid[slot] = 1'b1;
        l1_tag[slot]   = tag;
      end
      l2_lookup(addr, 1'b0, flags);
    end else if (!hit) begin
      l2_lookup(addr, 1'b1, flags);
      l1_valid[slot] = 1'b1;
      l1_tag[slot]   = tag;
    end
    return flags;
  endfunction

  function automatic void compare_flag(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    access_flags_t want;
    if (rst) begin
      for (int i = 0; i < L1_DEPTH; i++) begin
        l1_valid[i] = 1'b0;
        l1_tag[i]   = '0;
      end
      for (int i = 0; i < L2_SETS*L2_WAYS; i++) begin
        l2_valid[i] = 1'b0;
        l2_tag[i]   = '0;
      end
      victim_lfsr = SEED_RESET;
      pending_flags_q.delete();
    end else begin
      if (cfg_we) victim_lfsr = (cfg_wdata == '0) ? SEED_RESET : cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (pending_flags_q.size() == 0) begin
          $error("result item with no access waiting for it");
          error_count++;
        end else begin
          want = pending_flags_q.pop_front();
          compare_flag("l1_hit",      want.l1_hit,      m_tdata[0]);
          compare_flag("l2_accessed", want.l2_accessed, m_tdata[1]);
          compare_flag("l2_hit",      want.l2_hit,      m_tdata[2]);
          compare_flag("dram_read",   want.dram_read,   m_tdata[3]);
          compare_flag("dram_write",  want.dram_write,  m_tdata[4]);
        end
      end
      if (s_tvalid && s_tready) pending_flags_q.push_back(predict_access(s_tuser, s_tdata));
    end
    outstanding = pending_flags_q.size();
  end

endmodule
`default_nettype wire

// File: bench/tb_two_level_cache_tag_hierarchy_top.sv
`default_nettype none
// Top of the cache tag testbench. It generates the access stream, the output
// back-pressure and the seed writes; the checker beside the block does all
// of the prediction and comparison and reports its failure count here.
module tb_two_level_cache_tag_hierarchy_top;
  import tlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [ADDR_W-1:0] s_tdata   = '0;
  logic [1:0]        s_tuser   = MODE_READ;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [7:0]        m_tdata;
  logic              cfg_we    = 1'b0;
  logic [LFSR_W-1:0] cfg_wdata = '0;

  int errors;
  int outstanding;

  // When low, neither side inserts idle cycles.
  logic gaps_on = 1'b1;

  // Small pools of L2 tags and sets. Six tags spread over three sets are
  // enough to overflow the four ways regularly, so replacement gets exercised.
  logic [L2_TAG_W-1:0] tag_pool [6];
  logic [L2_SET_W-1:0] set_pool [3];
  logic [ADDR_W-1:0]   recent   [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_level_cache_tag_hierarchy_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cache_tag_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .error_count (errors),
    .outstanding (outstanding)
  );

  // The receiver stalls in roughly a quarter of the cycles unless gaps are off.
  always @(negedge clk) m_tready = !gaps_on || ($urandom_range(0, 99) >= 26);

  // Presents one access, possibly after some idle cycles, and returns at the
  // rising edge where it was taken. Valid stays high into the next call, so
  // back-to-back items go out without a bubble.
  task automatic send_access(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    while (gaps_on && ($urandom_range(0, 99) < 26)) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = addr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drops valid and waits until every access has been answered, then lets a
  // few more cycles go by so the pipeline is truly empty.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    for (int n = 0; (n < 4000) && (outstanding != 0); n++) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The seed is only loaded while the block is idle.
  task automatic load_seed(input logic [LFSR_W-1:0] seed);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = seed;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return MODE_READ;
    if (r < 68) return MODE_WRITE;
    if (r < 94) return MODE_FETCH;
    return MODE_NONE;
  endfunction

  // Mostly addresses from the hot pools so sets fill up and L1 lines
  // conflict; some repeats of recent addresses for L1 hits; the rest fully
  // random so every address bit toggles.
  function automatic logic [ADDR_W-1:0] pick_address();
    int                r;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(0, 99);
    if (r < 55)
      addr = {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 2)],
              OFF_W'($urandom)};
    else if (r < 80)
      addr = recent[$urandom_range(0, 3)];
    else
      addr = $urandom;
    recent[$urandom_range(0, 3)] = addr;
    return addr;
  endfunction

  initial begin : stimulus
    int                accesses;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [LFSR_W-1:0] seeds [5];

    // Extremes first, then a zero write that must fall back to the reset seed,
    // then two random seeds.
    seeds[0] = 16'hFFFF;
    seeds[1] = 16'h0001;
    seeds[2] = 16'h0000;
    seeds[3] = 16'($urandom);
    seeds[4] = 16'($urandom_range(1, 65535));
    for (int i = 0; i < 4; i++) recent[i] = $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, run with the reset seed. The block is still clearing its
    // memories here; tready holds the first item back until that is done.
    send_access(MODE_READ,  32'h0000_0000);   // cold miss everywhere, DRAM read
    send_access(MODE_READ,  32'h0000_003F);   // same line, L1 hit
    send_access(MODE_WRITE, 32'h0000_0000);   // write hit in L1, still goes to L2
    send_access(MODE_FETCH, 32'h0000_0010);   // instruction half misses, L2 hits
    send_access(MODE_FETCH, 32'h0000_0000);   // instruction half now hits
    send_access(MODE_NONE,  32'hFFFF_FFFF);   // unused kind touches nothing
    send_access(MODE_NONE,  32'h0000_0000);
    send_access(MODE_READ,  32'hFFFF_FFFF);   // top of the address space
    send_access(MODE_WRITE, 32'hFFFF_FFC0);
    send_access(MODE_FETCH, 32'hFFFF_FFFF);
    send_access(MODE_WRITE, 32'h1234_5678);   // write miss: allocate, no DRAM read
    send_access(MODE_READ,  32'h1234_5678);

    // Five distinct tags into one L2 set by writes: the fifth evicts without a
    // DRAM read. Then a read of a sixth tag evicts with a DRAM read as well.
    for (int t = 1; t <= 5; t++)
      send_access(MODE_WRITE, {16'(t), 10'h155, 6'h00});
    send_access(MODE_READ,  {16'd6, 10'h155, 6'h21});
    send_access(MODE_READ,  {16'd5, 10'h155, 6'h3F});
    send_access(MODE_FETCH, {16'd1, 10'h155, 6'h00});
    send_access(MODE_WRITE, {16'd2, 10'h155, 6'h08});

    // Random phases, one per seed setting. The first one opens with a long
    // stretch where neither side idles.
    for (int p = 0; p < 5; p++) begin
      load_seed(seeds[p]);
      for (int i = 0; i < 6; i++) tag_pool[i] = L2_TAG_W'($urandom);
      for (int i = 0; i < 3; i++) set_pool[i] = L2_SET_W'($urandom);
      accesses = 0;
      while (accesses < 270) begin
        gaps_on = !((p == 0) && (accesses < 150));
        kind = pick_kind();
        addr = pick_address();
        send_access(kind, addr);
        accesses++;
      end
    end

    drain();
    if (outstanding != 0) $error("%0d accesses still unanswered", outstanding);
    if ((errors == 0) && (outstanding == 0))
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
